FILE: src/tac_pkg.sv
// Shared types and constants for the timing anomaly confidence block.
// No dependencies; used by every module under src.
package tac_pkg;

    localparam int SAMPLE_W    = 28;
    localparam int TOL_W       = 8;
    localparam int CONF_W      = 7;
    localparam int COUNT_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 28;

    // diff * 100 and nominal * tolerance
    localparam int SCALED_W    = SAMPLE_W + 7;
    localparam int PRODUCT_W   = SAMPLE_W + TOL_W;
    // anomalies * 100 over a 16 bit count
    localparam int PCT_W       = COUNT_W + 7;

    localparam logic [COUNT_W-1:0] MAX_SAMPLES = 16'd65535;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 8'd10;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NOMINAL   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 2'd1;

    // confidence grades
    localparam logic [CONF_W-1:0] CONF_HIGH = 7'd90;
    localparam logic [CONF_W-1:0] CONF_MID  = 7'd75;
    localparam logic [CONF_W-1:0] CONF_LOW  = 7'd50;
    localparam logic [CONF_W-1:0] CONF_MIN  = 7'd30;
    localparam logic [CONF_W-1:0] CONF_NONE = 7'd0;

    // floor(a*100/s) > N  <=>  a*100 >= (N+1)*s
    localparam logic [6:0] PCT_HIGH_MUL = 7'd51;
    localparam logic [6:0] PCT_MID_MUL  = 7'd31;
    localparam logic [6:0] PCT_LOW_MUL  = 7'd16;
    localparam logic [6:0] PCT_MIN_MUL  = 7'd6;

    // word moving from the screening stages to the tally
    typedef struct packed {
        logic valid;
        logic last;
        logic anomaly;
    } judged_t;

endpackage

FILE: src/timing_anomaly_confidence.sv
// Timing anomaly confidence detector, top level.
// The last sample passes the screen input and scaled registers, then the tally
// capture and result registers. Throughput: one sample per cycle; the whole
// pipeline stalls only while a result word waits on m_ready.
// Reset (aresetn, synchronous): counters and valids clear, nominal_time = 0,
// tolerance_percent = 10. Uses tac_pkg, tac_screen, tac_tally.
module timing_anomaly_confidence (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tac_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tac_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tac_pkg::SAMPLE_W-1:0]      s_sample_time,
    input  logic                              s_last_sample,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tac_pkg::CONF_W-1:0]        m_confidence,
    output logic [tac_pkg::COUNT_W-1:0]       m_anomaly_total
);

    logic [tac_pkg::SAMPLE_W-1:0] nominal_reg;
    logic [tac_pkg::TOL_W-1:0]    tolerance_reg;
    logic                         en;
    tac_pkg::judged_t             judged;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nominal_reg   <= '0;
            tolerance_reg <= tac_pkg::TOL_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tac_pkg::REG_NOMINAL:   nominal_reg   <= cfg_data[tac_pkg::SAMPLE_W-1:0];
                tac_pkg::REG_TOLERANCE: tolerance_reg <= cfg_data[tac_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // pipeline advances unless a result word is held
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    tac_screen u_screen (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .en                (en),
        .in_valid          (s_valid),
        .sample_time       (s_sample_time),
        .last_sample       (s_last_sample),
        .nominal_time      (nominal_reg),
        .tolerance_percent (tolerance_reg),
        .judged            (judged)
    );

    tac_tally u_tally (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .judged        (judged),
        .nominal_zero  (nominal_reg == '0),
        .out_valid     (m_valid),
        .confidence    (m_confidence),
        .anomaly_total (m_anomaly_total)
    );

endmodule

FILE: src/tac_screen.sv
// Sample screening: input register, scaled deviation and threshold product,
// then the anomaly compare. Depends on tac_pkg.
module tac_screen (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [tac_pkg::SAMPLE_W-1:0]   sample_time,
    input  logic                           last_sample,
    input  logic [tac_pkg::SAMPLE_W-1:0]   nominal_time,
    input  logic [tac_pkg::TOL_W-1:0]      tolerance_percent,
    output tac_pkg::judged_t               judged
);

    logic                          in_valid_reg;
    logic                          in_last_reg;
    logic [tac_pkg::SAMPLE_W-1:0]  in_sample_reg;

    logic                          sc_valid_reg;
    logic                          sc_last_reg;
    logic [tac_pkg::SCALED_W-1:0]  scaled_reg;
    logic [tac_pkg::PRODUCT_W-1:0] product_reg;

    logic [tac_pkg::SAMPLE_W-1:0]  diff;
    logic [tac_pkg::SCALED_W-1:0]  scaled_next;
    logic [tac_pkg::PRODUCT_W-1:0] product_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            sc_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= in_valid;
            sc_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_sample_reg <= sample_time;
            in_last_reg   <= last_sample;
            sc_last_reg   <= in_last_reg;
            scaled_reg    <= scaled_next;
            product_reg   <= product_next;
        end
    end

    // diff > floor(P/100)  <=>  100*diff > P, so no divider is needed
    always_comb begin
        if (in_sample_reg >= nominal_time) begin
            diff = in_sample_reg - nominal_time;
        end else begin
            diff = nominal_time - in_sample_reg;
        end
        scaled_next  = (tac_pkg::SCALED_W'(diff) << 6) + (tac_pkg::SCALED_W'(diff) << 5)
                     + (tac_pkg::SCALED_W'(diff) << 2);
        product_next = tac_pkg::PRODUCT_W'(nominal_time)
                     * tac_pkg::PRODUCT_W'(tolerance_percent);
    end

    assign judged.valid   = sc_valid_reg;
    assign judged.last    = sc_last_reg;
    assign judged.anomaly = (tac_pkg::PRODUCT_W'(scaled_reg) > product_reg);

endmodule

FILE: src/tac_tally.sv
// Stream counters, end-of-stream capture and confidence grading into the
// result register. Depends on tac_pkg.
module tac_tally (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  tac_pkg::judged_t              judged,
    input  logic                          nominal_zero,
    output logic                          out_valid,
    output logic [tac_pkg::CONF_W-1:0]    confidence,
    output logic [tac_pkg::COUNT_W-1:0]   anomaly_total
);

    logic [tac_pkg::COUNT_W-1:0] samples_reg,   samples_next;
    logic [tac_pkg::COUNT_W-1:0] anomalies_reg, anomalies_next;
    logic [tac_pkg::COUNT_W-1:0] samples_inc,   anomalies_inc;

    logic                        res_valid_reg;
    logic [tac_pkg::COUNT_W-1:0] res_samples_reg;
    logic [tac_pkg::COUNT_W-1:0] res_anomalies_reg;

    logic                        out_valid_reg;
    logic [tac_pkg::CONF_W-1:0]  conf_reg,  conf_next;
    logic [tac_pkg::COUNT_W-1:0] total_reg;

    logic [tac_pkg::PCT_W-1:0]   scaled_anom;
    logic [tac_pkg::PCT_W-1:0]   bound_high, bound_mid, bound_low, bound_min;

    always_comb begin
        samples_inc   = (samples_reg >= tac_pkg::MAX_SAMPLES) ? tac_pkg::MAX_SAMPLES
                                                               : samples_reg + 1'b1;
        anomalies_inc = anomalies_reg;
        if (judged.anomaly) begin
            anomalies_inc = (anomalies_reg >= tac_pkg::MAX_SAMPLES) ? tac_pkg::MAX_SAMPLES
                                                                     : anomalies_reg + 1'b1;
        end
        samples_next   = samples_reg;
        anomalies_next = anomalies_reg;
        if (en && judged.valid) begin
            // stream end clears both counters
            samples_next   = judged.last ? '0 : samples_inc;
            anomalies_next = judged.last ? '0 : anomalies_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samples_reg   <= '0;
            anomalies_reg <= '0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            samples_reg   <= samples_next;
            anomalies_reg <= anomalies_next;
            if (en) begin
                res_valid_reg <= judged.valid && judged.last;
                out_valid_reg <= res_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && judged.valid && judged.last) begin
            res_samples_reg   <= samples_inc;
            res_anomalies_reg <= anomalies_inc;
        end
        if (en && res_valid_reg) begin
            conf_reg  <= conf_next;
            total_reg <= res_anomalies_reg;
        end
    end

    // percentage thresholds as constant multiples of the sample count
    always_comb begin
        scaled_anom = tac_pkg::PCT_W'(res_anomalies_reg) * tac_pkg::PCT_W'(7'd100);
        bound_high  = tac_pkg::PCT_W'(res_samples_reg) * tac_pkg::PCT_W'(tac_pkg::PCT_HIGH_MUL);
        bound_mid   = tac_pkg::PCT_W'(res_samples_reg) * tac_pkg::PCT_W'(tac_pkg::PCT_MID_MUL);
        bound_low   = tac_pkg::PCT_W'(res_samples_reg) * tac_pkg::PCT_W'(tac_pkg::PCT_LOW_MUL);
        bound_min   = tac_pkg::PCT_W'(res_samples_reg) * tac_pkg::PCT_W'(tac_pkg::PCT_MIN_MUL);
        if (nominal_zero) begin
            conf_next = tac_pkg::CONF_NONE;
        end else if (scaled_anom >= bound_high) begin
            conf_next = tac_pkg::CONF_HIGH;
        end else if (scaled_anom >= bound_mid) begin
            conf_next = tac_pkg::CONF_MID;
        end else if (scaled_anom >= bound_low) begin
            conf_next = tac_pkg::CONF_LOW;
        end else if (scaled_anom >= bound_min) begin
            conf_next = tac_pkg::CONF_MIN;
        end else begin
            conf_next = tac_pkg::CONF_NONE;
        end
    end

    assign out_valid     = out_valid_reg;
    assign confidence    = conf_reg;
    assign anomaly_total = total_reg;

endmodule

FILE: src/tac_checker.sv
// Port-level checks for timing_anomaly_confidence, bound to the top level.
// Depends on tac_pkg.
module tac_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [tac_pkg::CONF_W-1:0]      m_confidence,
    input logic [tac_pkg::COUNT_W-1:0]     m_anomaly_total
);

    // no result word right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_confidence)
                                && $stable(m_anomaly_total))
        else $error("stalled result word changed");

    a_grade: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_confidence == tac_pkg::CONF_NONE || m_confidence == tac_pkg::CONF_MIN
                 || m_confidence == tac_pkg::CONF_LOW || m_confidence == tac_pkg::CONF_MID
                 || m_confidence == tac_pkg::CONF_HIGH)
        else $error("confidence not a legal grade");

    // any nonzero grade needs at least one anomaly
    a_grade_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_confidence != tac_pkg::CONF_NONE |-> m_anomaly_total != '0)
        else $error("nonzero confidence with no anomalies");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result word held");

endmodule

bind timing_anomaly_confidence tac_checker u_tac_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_confidence    (m_confidence),
    .m_anomaly_total (m_anomaly_total)
);
